>>> rtl/mat_pkg.sv
`default_nettype none

package mat_pkg;

    localparam int MAX_WINDOW = 256;
    localparam int SAMPLE_W   = 32;
    localparam int SUM_W      = 40;
    localparam int LEN_W      = $clog2(MAX_WINDOW) + 1;
    localparam int PTR_W      = $clog2(MAX_WINDOW);
    localparam int DIV_STEPS  = SUM_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [SUM_W-1:0]    sum_t;
    typedef logic [SUM_W-1:0]           mag_t;
    typedef logic [LEN_W-1:0]           len_t;
    typedef logic [PTR_W-1:0]           ptr_t;

endpackage

`default_nettype wire

>>> rtl/moving_average_trend.sv
`default_nettype none

// channel   | dir | signals                          | contents
// ----------+-----+----------------------------------+------------------------------------
// sample in | in  | s_tvalid s_tready s_tdata[31:0]  | sample (Q16.16, signed)
// result    | out | m_tvalid m_tready m_tdata[31:0]  | average; tuser [0] rising [1] falling
// config    | in  | cfg_we cfg_data[8:0]             | window_length
//
// Each accepted sample passes through the delta, sum, load, divide and done states in
// turn; the divide state runs the 40-step bit-serial divider. A new sample is accepted
// once the previous one has been handed to the output register. A stalled output holds
// the block in its final step until the result register frees. Reset and a window_length
// write clear the ring at once through per-entry valid bits.
module moving_average_trend (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] sample
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [31:0] average
    output logic [1:0]       m_tuser,   // [0] rising, [1] falling
    input  wire logic        cfg_we,
    input  wire logic [8:0]  cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DELTA,
        ST_SUM,
        ST_LOAD,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t                           state_reg;
    mat_pkg::sample_t                 ring [mat_pkg::MAX_WINDOW];
    logic [mat_pkg::MAX_WINDOW-1:0]   valid_reg;
    mat_pkg::sample_t                 rd_data_reg;
    logic                             old_valid_reg;
    mat_pkg::sample_t                 sample_reg;
    logic signed [mat_pkg::SAMPLE_W:0] delta_reg;
    mat_pkg::sum_t                    sum_reg;
    mat_pkg::ptr_t                    wp_reg;
    mat_pkg::len_t                    warm_reg;
    mat_pkg::len_t                    len_reg;
    logic                             rise_reg;
    logic                             fall_reg;
    logic                             neg_reg;
    logic                             m_tvalid_reg;
    logic [31:0]                      avg_reg;
    logic [1:0]                       flags_reg;

    logic                             accept;
    mat_pkg::ptr_t                    oldest;
    mat_pkg::sample_t                 old_val;
    mat_pkg::len_t                    warm_next;
    mat_pkg::len_t                    len_next;
    mat_pkg::mag_t                    sum_mag;
    mat_pkg::mag_t                    quot;
    mat_pkg::mag_t                    result;
    logic                             div_done;
    logic                             out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign oldest   = wp_reg - len_reg[mat_pkg::PTR_W-1:0];
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        old_val   = old_valid_reg ? rd_data_reg : '0;
        warm_next = (warm_reg < len_reg) ? warm_reg + 1'b1 : warm_reg;
        sum_mag   = sum_reg[mat_pkg::SUM_W-1] ? mat_pkg::mag_t'(-sum_reg)
                                              : mat_pkg::mag_t'(sum_reg);
        result    = neg_reg ? -quot : quot;
        if (cfg_data == '0)
            len_next = mat_pkg::len_t'(1);
        else if (cfg_data > mat_pkg::len_t'(mat_pkg::MAX_WINDOW))
            len_next = mat_pkg::len_t'(mat_pkg::MAX_WINDOW);
        else
            len_next = cfg_data;
    end

    mat_serial_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == ST_LOAD),
        .dividend (sum_mag),
        .divisor  (len_reg),
        .done     (div_done),
        .quotient (quot)
    );

    // sample ring
    always_ff @(posedge clk)
    begin
        if (accept)
            rd_data_reg <= ring[oldest];
        if (state_reg == ST_DELTA)
            ring[wp_reg] <= sample_reg;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            sample_reg <= s_tdata;
        if (state_reg == ST_DELTA)
            delta_reg <= (mat_pkg::SAMPLE_W+1)'(sample_reg) - (mat_pkg::SAMPLE_W+1)'(old_val);
        if (state_reg == ST_LOAD)
            neg_reg <= sum_reg[mat_pkg::SUM_W-1];
        if ((state_reg == ST_DONE) && out_free)
        begin
            avg_reg   <= result[31:0];
            flags_reg <= {fall_reg, rise_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            old_valid_reg <= 1'b0;
            sum_reg       <= '0;
            wp_reg        <= '0;
            warm_reg      <= '0;
            len_reg       <= mat_pkg::len_t'(1);
            rise_reg      <= 1'b0;
            fall_reg      <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            if ((state_reg == ST_DONE) && out_free)
                m_tvalid_reg <= 1'b1;
            else if (m_tvalid_reg && m_tready)
                m_tvalid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        old_valid_reg <= valid_reg[oldest];
                        state_reg     <= ST_DELTA;
                    end
                end
                ST_DELTA:
                begin
                    valid_reg[wp_reg] <= 1'b1;
                    wp_reg            <= wp_reg + 1'b1;
                    warm_reg          <= warm_next;
                    if (warm_next >= len_reg)
                    begin
                        rise_reg <= (sample_reg > old_val);
                        fall_reg <= (sample_reg < old_val);
                    end
                    state_reg <= ST_SUM;
                end
                ST_SUM:
                begin
                    sum_reg   <= sum_reg + mat_pkg::SUM_W'(delta_reg);
                    state_reg <= ST_LOAD;
                end
                ST_LOAD:
                begin
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (div_done)
                        state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (out_free)
                        state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            if (cfg_we)
            begin
                len_reg   <= len_next;
                valid_reg <= '0;
                sum_reg   <= '0;
                wp_reg    <= '0;
                warm_reg  <= '0;
                rise_reg  <= 1'b0;
                fall_reg  <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = avg_reg;
    assign m_tuser  = flags_reg;

    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(rise_reg && fall_reg))
        else $error("rising and falling both set");

    a_warmup_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (warm_reg < len_reg) |-> (!rise_reg && !fall_reg))
        else $error("trend flag set during warm-up");

    a_warm_bound: assert property (@(posedge clk) disable iff (!rst_n)
        warm_reg <= len_reg)
        else $error("warm-up count beyond window length");

    a_div_owned: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside divide step");

endmodule

`default_nettype wire

>>> rtl/mat_serial_div.sv
`default_nettype none

// restoring divider, one quotient bit per cycle
module mat_serial_div (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire mat_pkg::mag_t dividend,
    input  wire mat_pkg::len_t divisor,
    output logic               done,
    output mat_pkg::mag_t      quotient
);

    mat_pkg::mag_t                 shift_reg;
    mat_pkg::len_t                 rem_reg;
    logic [mat_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;

    logic [mat_pkg::LEN_W:0] trial;
    logic [mat_pkg::LEN_W:0] diff;
    logic                    ge;

    always_comb
    begin
        trial = {rem_reg, shift_reg[mat_pkg::SUM_W-1]};
        diff  = trial - {1'b0, divisor};
        ge    = (trial >= {1'b0, divisor});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == mat_pkg::DIV_CNT_W'(mat_pkg::DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg <= dividend;
            rem_reg   <= '0;
        end
        else if (busy_reg)
        begin
            shift_reg <= {shift_reg[mat_pkg::SUM_W-2:0], ge};
            rem_reg   <= ge ? diff[mat_pkg::LEN_W-1:0] : trial[mat_pkg::LEN_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = shift_reg;

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 60;
    localparam int IDLE_PERCENT  = 15;
    localparam int QUIET_FIRST   = 450;
    localparam int QUIET_LAST    = 600;
    localparam int NUM_PHASES    = 8;

    localparam mat_pkg::sample_t SAMPLE_MAX = 32'sh7FFF_FFFF;
    localparam mat_pkg::sample_t SAMPLE_MIN = 32'sh8000_0000;

    typedef struct packed {
        mat_pkg::sample_t average;
        logic             rising;
        logic             falling;
    } trend_result_t;

    class trend_scoreboard;
        mat_pkg::sample_t ring [mat_pkg::MAX_WINDOW];
        mat_pkg::sum_t    window_total;
        mat_pkg::ptr_t    head;
        int unsigned      filled;
        mat_pkg::len_t    span;
        logic             rising;
        logic             falling;
        trend_result_t    pending_averages [$];
        int unsigned      errors;

        function new();
            errors = 0;
            span   = 1;
            clear_window();
        endfunction

        function void clear_window();
            foreach (ring[i])
                ring[i] = '0;
            window_total = '0;
            head         = '0;
            filled       = 0;
            rising       = 1'b0;
            falling      = 1'b0;
        endfunction

        function void set_length(logic [8:0] value);
            if (value == 0)
                span = 1;
            else if (value > mat_pkg::MAX_WINDOW)
                span = mat_pkg::len_t'(mat_pkg::MAX_WINDOW);
            else
                span = mat_pkg::len_t'(value);
            clear_window();
        endfunction

        // advance the window by one sample and queue the expected average and trend flags
        function void note_sample(mat_pkg::sample_t value);
            mat_pkg::ptr_t oldest;
            mat_pkg::sum_t prev_total;
            mat_pkg::sum_t quotient;
            trend_result_t exp_res;
            oldest       = mat_pkg::ptr_t'(head - span[mat_pkg::PTR_W-1:0]);
            prev_total   = window_total;
            window_total = window_total - mat_pkg::sum_t'(ring[oldest]);
            ring[head]   = value;
            window_total = window_total + mat_pkg::sum_t'(value);
            head         = head + 1'b1;
            if (filled < span)
                filled++;
            if (filled >= span) begin
                rising  = window_total > prev_total;
                falling = window_total < prev_total;
            end
            quotient = window_total
                       / $signed({{(mat_pkg::SUM_W-mat_pkg::LEN_W){1'b0}}, span});
            exp_res.average = quotient[mat_pkg::SAMPLE_W-1:0];
            exp_res.rising  = rising;
            exp_res.falling = falling;
            pending_averages.push_back(exp_res);
        endfunction

        function void check_result(logic [31:0] data, logic [1:0] flags);
            trend_result_t exp_res;
            if (pending_averages.size() == 0) begin
                $display("%0t: unexpected result, actual average %h flags %b",
                         $realtime, data, flags);
                errors++;
                return;
            end
            exp_res = pending_averages.pop_front();
            if (data !== exp_res.average) begin
                $display("%0t: average expected %h actual %h",
                         $realtime, exp_res.average, data);
                errors++;
            end
            if (flags[0] !== exp_res.rising) begin
                $display("%0t: rising expected %b actual %b",
                         $realtime, exp_res.rising, flags[0]);
                errors++;
            end
            if (flags[1] !== exp_res.falling) begin
                $display("%0t: falling expected %b actual %b",
                         $realtime, exp_res.falling, flags[1]);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return pending_averages.size();
        endfunction
    endclass

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_we   = 1'b0;
    logic [8:0]  cfg_data = '0;

    trend_scoreboard  sb;
    int unsigned      sent_count  = 0;
    int unsigned      cycle_count = 0;
    mat_pkg::sample_t last_sample = '0;

    moving_average_trend i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic bit quiet_stretch();
        return sent_count >= QUIET_FIRST && sent_count < QUIET_LAST;
    endfunction

    always @(negedge clk)
    begin
        m_tready <= quiet_stretch() || ($urandom_range(99) >= IDLE_PERCENT);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic mat_pkg::sample_t draw_sample();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 10)
            return SAMPLE_MAX;
        else if (pick < 20)
            return SAMPLE_MIN;
        else if (pick < 40)
            return mat_pkg::sample_t'(int'($urandom_range(2000)) - 1000);
        else if (pick < 50)
            return last_sample;
        else
            return mat_pkg::sample_t'($urandom);
    endfunction

    // entered and left just after a falling edge
    task automatic send_sample(mat_pkg::sample_t value);
        while (!quiet_stretch() && $urandom_range(99) < IDLE_PERCENT) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_sample(value);
        last_sample = value;
        sent_count++;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_length(logic [8:0] value);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we   <= 1'b0;
        sb.set_length(value);
        @(negedge clk);
    endtask

    initial
    begin
        mat_pkg::sample_t directed [20];
        logic [8:0]       phase_len [NUM_PHASES];
        int unsigned      phase_items [NUM_PHASES];

        sb = new();
        directed = '{SAMPLE_MAX, SAMPLE_MIN, 32'sd0, -32'sd1, 32'sd1, 32'sd1,
                     32'sh0001_0000, 32'sh8000_0001, 32'sh7FFF_FFFE, 32'sh0000_FFFF,
                     -32'sh0001_0000, 32'sh5555_5555, 32'shAAAA_AAAA, 32'shAAAA_AAAA,
                     32'sh0F0F_0F0F, 32'shF0F0_F0F0, SAMPLE_MAX, SAMPLE_MAX,
                     SAMPLE_MIN, 32'sd0};
        phase_len   = '{9'd0, 9'd511, 9'd2, 9'd257,
                        9'($urandom_range(1, 256)), 9'd1,
                        9'($urandom_range(3, 255)), 9'd3};
        phase_items = '{30, 300, 80, 20, 150, 60, 150, 40};

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed[i])
            send_sample(directed[i]);

        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_idle();
            write_length(phase_len[p]);
            for (int i = 0; i < phase_items[p]; i++) begin
                // short window driven to both sum extremes first
                if (phase_len[p] == 9'd3 && i < 8)
                    send_sample(i < 4 ? SAMPLE_MAX : SAMPLE_MIN);
                else
                    send_sample(draw_sample());
            end
        end

        wait_idle();
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
rtl/mat_pkg.sv
rtl/mat_serial_div.sv
rtl/moving_average_trend.sv
tb/tb_top.sv
